>>> hw/rtl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared widths, types and sizing for the per-second mean decimator.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_GROUP   = 255;

  localparam int SEC_BITS    = 32;
  localparam int GSIZE_BITS  = 8;
  localparam int COUNT_BITS  = $clog2(MAX_GROUP + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS   = $clog2(SUM_BITS);
  localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic        [SEC_BITS-1:0]    sec_t;

  // accumulator command
  typedef struct packed {
    logic load;   // open a group with this sample
    logic add;    // add this sample to the open group
  } acc_op_t;

  typedef struct packed {
    logic   start;
    sum_t   dividend;
    count_t divisor;
  } div_req_t;

  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/pmd_in_if.sv
// ----------------------------------------------------------------------------
// pmd_in_if
// Sample channel: one timestamped multi-channel sensor word per handshake.
// ----------------------------------------------------------------------------
interface pmd_in_if;
  import pmd_pkg::*;

  logic    valid;
  logic    ready;
  sec_t    second_stamp;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;
  sample_t sample_ch4;
  sample_t sample_ch5;

  modport source (
    output valid, second_stamp, sample_ch0, sample_ch1, sample_ch2,
           sample_ch3, sample_ch4, sample_ch5,
    input  ready
  );

  modport sink (
    input  valid, second_stamp, sample_ch0, sample_ch1, sample_ch2,
           sample_ch3, sample_ch4, sample_ch5,
    output ready
  );

endinterface

>>> hw/rtl/pmd_out_if.sv
// ----------------------------------------------------------------------------
// pmd_out_if
// Result channel: one finished second's channel means per handshake.
// ----------------------------------------------------------------------------
interface pmd_out_if;
  import pmd_pkg::*;

  logic                  valid;
  logic                  ready;
  sec_t                  emitted_second;
  sample_t               mean_ch0;
  sample_t               mean_ch1;
  sample_t               mean_ch2;
  sample_t               mean_ch3;
  sample_t               mean_ch4;
  sample_t               mean_ch5;
  logic [GSIZE_BITS-1:0] group_size;

  modport source (
    output valid, emitted_second, mean_ch0, mean_ch1, mean_ch2, mean_ch3,
           mean_ch4, mean_ch5, group_size,
    input  ready
  );

  modport sink (
    input  valid, emitted_second, mean_ch0, mean_ch1, mean_ch2, mean_ch3,
           mean_ch4, mean_ch5, group_size,
    output ready
  );

endinterface

>>> hw/rtl/per_second_mean_decimator.sv
// ----------------------------------------------------------------------------
// per_second_mean_decimator
// Averages timestamped sensor samples over each whole second.
//
//   channel  dir  handshake     word
//   in_i     in   valid/ready   second_stamp, sample_ch0..sample_ch5
//   out_o    out  valid/ready   emitted_second, mean_ch0..mean_ch5, group_size
//
// A sample in the open second, or the first sample, goes into the sums at once.
// A sample with a new second waits while the one shared divider works through
// the channel sums in turn, one quotient bit per cycle. in_i.ready is low while
// it divides, and while the finished word waits for a free output register.
// Reset is asynchronous, active low, and clears sums, count and the group.
// The last group is never emitted, since no later sample closes it.
// ----------------------------------------------------------------------------
module per_second_mean_decimator (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmd_in_if.sink    in_i,
  pmd_out_if.source out_o
);
  import pmd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DRAIN
  } state_e;

  state_e                      state_q;
  logic                        group_open_q;
  sec_t                        cur_sec_q;
  sec_t                        pend_sec_q;
  sample_t [CHANNELS-1:0]      pend_q;
  sample_t [CHANNELS-1:0]      means_q;
  logic    [CH_BITS-1:0]       ch_q;
  logic                        start_q;

  logic                        out_valid_q;
  sec_t                        out_sec_q;
  sample_t [CHANNELS-1:0]      out_means_q;
  logic    [GSIZE_BITS-1:0]    out_size_q;

  sample_t [CHANNELS-1:0]      in_samples;
  sum_t    [CHANNELS-1:0]      sums;
  count_t                      count;
  acc_op_t                     acc_op;
  sample_t [CHANNELS-1:0]      acc_samples;
  div_req_t                    div_req;
  div_rsp_t                    div_rsp;

  logic                        accept;
  logic                        is_new;
  logic                        out_free;
  logic                        drain_go;

  assign in_samples[0] = in_i.sample_ch0;
  assign in_samples[1] = in_i.sample_ch1;
  assign in_samples[2] = in_i.sample_ch2;
  assign in_samples[3] = in_i.sample_ch3;
  assign in_samples[4] = in_i.sample_ch4;
  assign in_samples[5] = in_i.sample_ch5;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign is_new     = group_open_q && (in_i.second_stamp != cur_sec_q);
  assign out_free   = !out_valid_q || out_o.ready;
  assign drain_go   = (state_q == ST_DRAIN) && out_free;

  // a sample in the open second is summed right away, a new second waits
  always_comb begin
    acc_op      = '0;
    acc_samples = in_samples;
    if (accept && !is_new) begin
      acc_op.load = !group_open_q;
      acc_op.add  = group_open_q;
    end else if (drain_go) begin
      acc_op.load = 1'b1;
      acc_samples = pend_q;
    end
  end

  pmd_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (acc_op),
    .samples_i (acc_samples),
    .sums_o    (sums),
    .count_o   (count)
  );

  assign div_req.start    = start_q;
  assign div_req.dividend = sums[ch_q];
  assign div_req.divisor  = count;

  pmd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      group_open_q <= 1'b0;
      cur_sec_q    <= '0;
      ch_q         <= '0;
      start_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (is_new) begin
              ch_q    <= '0;
              start_q <= 1'b1;
              state_q <= ST_DIV;
            end else if (!group_open_q) begin
              group_open_q <= 1'b1;
              cur_sec_q    <= in_i.second_stamp;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            if (ch_q == CH_BITS'(CHANNELS - 1)) begin
              state_q <= ST_DRAIN;
            end else begin
              ch_q    <= ch_q + CH_BITS'(1);
              start_q <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            cur_sec_q   <= pend_sec_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_sec_q <= in_i.second_stamp;
      pend_q     <= in_samples;
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      means_q[ch_q] <= div_rsp.quotient;
    end
    if (drain_go) begin
      out_sec_q   <= cur_sec_q;
      out_means_q <= means_q;
      out_size_q  <= GSIZE_BITS'(count);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.emitted_second = out_sec_q;
  assign out_o.mean_ch0       = out_means_q[0];
  assign out_o.mean_ch1       = out_means_q[1];
  assign out_o.mean_ch2       = out_means_q[2];
  assign out_o.mean_ch3       = out_means_q[3];
  assign out_o.mean_ch4       = out_means_q[4];
  assign out_o.mean_ch5       = out_means_q[5];
  assign out_o.group_size     = out_size_q;

`ifndef NO_ASSERTIONS
  a_word_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DRAIN))
    else $error("output word raised outside drain");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_open_q |-> (count != '0) && (count <= COUNT_BITS'(MAX_GROUP)))
    else $error("open group with bad sample count");

  a_sums_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && $past(state_q == ST_DIV) |-> $stable(sums) && $stable(count))
    else $error("sums changed while dividing");
`endif

endmodule

>>> hw/rtl/pmd_accum.sv
// ----------------------------------------------------------------------------
// pmd_accum
// Per-channel running sums and the saturating sample count of one group.
// ----------------------------------------------------------------------------
module pmd_accum (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pmd_pkg::acc_op_t                      op_i,
  input  pmd_pkg::sample_t [pmd_pkg::CHANNELS-1:0] samples_i,
  output pmd_pkg::sum_t    [pmd_pkg::CHANNELS-1:0] sums_o,
  output pmd_pkg::count_t                       count_o
);
  import pmd_pkg::*;

  sum_t   [CHANNELS-1:0] sums_q, sums_d;
  count_t                count_q, count_d;
  logic                  full;

  assign full = (count_q >= COUNT_BITS'(MAX_GROUP));

  always_comb begin
    sums_d  = sums_q;
    count_d = count_q;
    if (op_i.load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sums_d[c] = SUM_BITS'(samples_i[c]);
      end
      count_d = COUNT_BITS'(1);
    end else if (op_i.add && !full) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sums_d[c] = sums_q[c] + SUM_BITS'(samples_i[c]);
      end
      count_d = count_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q  <= '0;
      count_q <= '0;
    end else begin
      sums_q  <= sums_d;
      count_q <= count_d;
    end
  end

  assign sums_o  = sums_q;
  assign count_o = count_q;

endmodule

>>> hw/rtl/pmd_div.sv
// ----------------------------------------------------------------------------
// pmd_div
// Shared restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module pmd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmd_pkg::div_req_t req_i,
  output pmd_pkg::div_rsp_t rsp_o
);
  import pmd_pkg::*;

  logic [SUM_BITS-1:0]   quo_q;
  count_t                rem_q;
  count_t                div_q;
  logic [STEP_BITS-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic                  neg_q;
  logic                  zero_q;

  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  fits;
  logic [SUM_BITS-1:0]   magnitude;
  logic [SUM_BITS-1:0]   signed_quo;

  // magnitude of the most negative sum still fits as unsigned
  assign magnitude  = req_i.dividend[SUM_BITS-1] ? (~req_i.dividend + SUM_BITS'(1))
                                                 : req_i.dividend;
  assign rem_shift  = {rem_q, quo_q[SUM_BITS-1]};
  assign rem_diff   = rem_shift - {1'b0, div_q};
  assign fits       = (rem_shift >= {1'b0, div_q});
  assign signed_quo = neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + STEP_BITS'(1);
        if (cnt_q == STEP_BITS'(SUM_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q  <= magnitude;
      rem_q  <= '0;
      div_q  <= req_i.divisor;
      neg_q  <= req_i.dividend[SUM_BITS-1];
      zero_q <= (req_i.divisor == '0);
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_BITS-2:0], fits};
      rem_q <= fits ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = zero_q ? '0 : signed_quo[SAMPLE_BITS-1:0];

endmodule
